// ----- sv/ibc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the IMU bias calibration block.
// No dependencies; every other file imports this package.
package ibc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int SAMPLE_SHIFT = 16 - SAMPLE_BITS;
    localparam int NUM_LANES    = 3;
    localparam int NUM_CHAN     = 7;
    localparam int DIV_STEPS    = 32;
    localparam int MEAS_STEPS   = 2;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_MEASURE = 2'd0;
    localparam logic [1:0] CMD_CAL     = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_PARAM_ERR = 2'd1;
    localparam logic [1:0] STATUS_READ_ERR  = 2'd2;

    localparam logic [2:0] REG_ACCEL_RANGE  = 3'd0;
    localparam logic [2:0] REG_GYRO_RANGE   = 3'd1;
    localparam logic [2:0] REG_CAL_SAMPLES  = 3'd2;
    localparam logic [2:0] REG_CAL_ENABLE   = 3'd3;
    localparam logic [2:0] REG_ACCEL_BIAS_X = 3'd4;
    localparam logic [2:0] REG_ACCEL_BIAS_Y = 3'd5;
    localparam logic [2:0] REG_ACCEL_BIAS_Z = 3'd6;

    // gains applied before the constant divisions; 100/340 reduces to 5/17
    // and 1000/66 to 500/33
    localparam logic [9:0] MG_GAIN        = 10'd1000;
    localparam logic [9:0] GYRO_GAIN_HALF = 10'd500;
    localparam logic [9:0] TEMP_GAIN      = 10'd5;
    localparam logic signed [21:0] TEMP_OFFS = 22'sd3653;

    // reciprocals: floor(m / d) == (m * ceil(2^s / d)) >> s over the operand range
    localparam logic [51:0] RECIP_17        = 52'd493448;
    localparam int          RECIP_17_SHIFT  = 23;
    localparam logic [51:0] RECIP_131       = 52'd65572020;
    localparam int          RECIP_131_SHIFT = 33;
    localparam logic [51:0] RECIP_33        = 52'd65075263;
    localparam int          RECIP_33_SHIFT  = 31;
    localparam int          GYRO_16_SHIFT   = 4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MEAS = 2'd1,
        KIND_CAL  = 2'd2
    } kind_t;

    // Control from the sequencer to every divider lane.
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctrl_t;

    function automatic logic signed [15:0] sext_sample(input logic [15:0] v);
        logic [15:0] s;
        s = v << SAMPLE_SHIFT;
        return $signed(s) >>> SAMPLE_SHIFT;
    endfunction

    // magnitude of a sample times its gain
    function automatic logic [24:0] scale_mag(input logic signed [15:0] v,
                                              input logic [9:0] k);
        logic [15:0] m;
        m = v[15] ? 16'(-v) : v;
        return 25'(m) * 25'(k);
    endfunction

    function automatic logic [20:0] gyro_quot(input logic [24:0] m,
                                              input logic [1:0] range);
        logic [20:0] q;
        case (range)
            2'd0:    q = 21'((52'(m) * RECIP_131) >> RECIP_131_SHIFT);
            2'd1,
            2'd2:    q = 21'((52'(m) * RECIP_33) >> RECIP_33_SHIFT);
            default: q = 21'(m >> GYRO_16_SHIFT);
        endcase
        return q;
    endfunction

endpackage

// ----- sv/ibc_div_lane.sv -----
`timescale 1ns / 1ps
// One divider lane: signed dividend over unsigned divisor, one quotient bit a step,
// truncated toward zero. Depends on ibc_pkg.
module ibc_div_lane
    import ibc_pkg::*;
(
    input  logic                clk,
    input  lane_ctrl_t          ctrl,
    input  logic signed [32:0]  dividend,
    input  logic [16:0]         divisor,
    output logic signed [31:0]  quotient
);

    logic [31:0] quot_reg;
    logic [16:0] rem_reg;
    logic [16:0] divisor_reg;
    logic        neg_reg;
    logic [32:0] mag;
    logic [17:0] trial;
    logic [18:0] diff;

    assign mag   = dividend[32] ? 33'(-dividend) : dividend;
    assign trial = {rem_reg, quot_reg[31]};
    assign diff  = {1'b0, trial} - {2'b00, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            quot_reg    <= mag[31:0];
            rem_reg     <= '0;
            divisor_reg <= divisor;
            neg_reg     <= dividend[32];
        end
        else if (ctrl.step)
        begin
            if (!diff[18])
            begin
                rem_reg  <= diff[16:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[16:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
    end

    assign quotient = neg_reg ? -$signed(quot_reg) : $signed(quot_reg);

endmodule

// ----- sv/imu_bias_calibrate_and_scale.sv -----
`timescale 1ns / 1ps
// Top level of the IMU bias calibration and unit scaling block.
// Depends on ibc_pkg and ibc_div_lane.
//
// One transaction carries a raw seven-channel sample and a command. Measure
// scales accel to milli-g, gyro to milli-degrees per second and temperature
// to centi-degrees; calibration samples accumulate gyro sums and, on the last
// one, set the gyro biases to the truncated averages; clear zeroes the gyro
// biases. Seven scaling lanes (accel xyz, temperature, gyro xyz) run side by
// side: one step forms the magnitude times the gain, the next divides by the
// constant sensitivity with a shift or a reciprocal multiplication. Three
// divider lanes, one quotient bit per cycle, form the bias averages. A
// measure passes through load, 2 scaling steps and merge before its result
// is presented; the calibration sample that completes passes through load,
// 32 divide steps and merge; every other item goes from acceptance straight
// to merge. One item is in work at a time; a result waiting in the output
// register does not block acceptance of the next item. Configuration is to be
// written only while the block is idle; the block itself does not enforce it.
module imu_bias_calibrate_and_scale
    import ibc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] temp_raw,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic               read_failed,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               cal_done,
    output logic signed [14:0] accel_x_mg,
    output logic signed [14:0] accel_y_mg,
    output logic signed [14:0] accel_z_mg,
    output logic signed [14:0] temp_centi_c,
    output logic signed [21:0] gyro_x_mdps,
    output logic signed [21:0] gyro_y_mdps,
    output logic signed [21:0] gyro_z_mdps
);

    // configuration
    logic [1:0]         accel_range_reg, accel_range_next;
    logic [1:0]         gyro_range_reg, gyro_range_next;
    logic [15:0]        cal_samples_reg, cal_samples_next;
    logic               cal_enable_reg, cal_enable_next;
    logic signed [15:0] abias_reg [3];
    logic signed [15:0] abias_next [3];

    // calibration state
    logic signed [15:0] gbias_reg [3];
    logic signed [15:0] gbias_next [3];
    logic signed [31:0] sum_reg [3];
    logic signed [31:0] sum_next [3];
    logic [15:0]        taken_reg, taken_next;

    // sequencer
    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [1:0]         pend_status_reg, pend_status_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  last_step;
    lane_ctrl_t         ctrl;
    logic               scale_load, scale_mul, scale_div;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic               cal_done_reg, cal_done_next;
    logic signed [14:0] amg_reg [3];
    logic signed [14:0] amg_next [3];
    logic signed [14:0] temp_reg, temp_next;
    logic signed [21:0] gmd_reg [3];
    logic signed [21:0] gmd_next [3];

    // lane operands
    logic signed [15:0] acc_in [3];
    logic signed [15:0] gyr_in [3];
    logic signed [15:0] acc_adj [3];
    logic signed [15:0] gyr_adj [3];
    logic signed [31:0] sum_add [3];
    logic [15:0]        taken_inc;
    logic               cal_finish;
    logic signed [32:0] lane_dividend [NUM_LANES];
    logic [16:0]        lane_divisor [NUM_LANES];
    logic signed [31:0] lane_quot [NUM_LANES];
    logic signed [15:0] temp_in;

    // scaling lanes: 0..2 accel, 3 temperature, 4..6 gyro
    logic signed [15:0] samp_in [NUM_CHAN];
    logic [9:0]         chan_gain [NUM_CHAN];
    logic signed [15:0] samp_reg [NUM_CHAN];
    logic               sneg_reg [NUM_CHAN];
    logic [24:0]        mag_reg [NUM_CHAN];
    logic [20:0]        qmag_reg [NUM_CHAN];
    logic signed [21:0] sval [NUM_CHAN];

    assign acc_in[0] = sext_sample(accel_x);
    assign acc_in[1] = sext_sample(accel_y);
    assign acc_in[2] = sext_sample(accel_z);
    assign gyr_in[0] = sext_sample(gyro_x);
    assign gyr_in[1] = sext_sample(gyro_y);
    assign gyr_in[2] = sext_sample(gyro_z);
    assign temp_in   = sext_sample(temp_raw);
    assign taken_inc = taken_reg + 16'd1;
    assign cal_finish = (taken_inc >= cal_samples_reg) || (taken_inc == 16'd0);
    assign last_step = (kind_reg == KIND_CAL) ? STEP_W'(DIV_STEPS - 1)
                                              : STEP_W'(MEAS_STEPS - 1);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // wrap the bias subtraction to the sample width
            acc_adj[i] = cal_enable_reg ? sext_sample(16'(acc_in[i] - abias_reg[i]))
                                        : acc_in[i];
            gyr_adj[i] = cal_enable_reg ? sext_sample(16'(gyr_in[i] - gbias_reg[i]))
                                        : gyr_in[i];
            sum_add[i] = sum_reg[i] + 32'(gyr_in[i]);
        end
    end

    // Divider operands: bias averages on the final calibration sample.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_dividend[i] = 33'(sum_add[i]);
            lane_divisor[i]  = {taken_inc == 16'd0, taken_inc};
        end
    end

    // Scaling operands and gains per channel.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            samp_in[i]       = acc_adj[i];
            samp_in[4 + i]   = gyr_adj[i];
            chan_gain[i]     = MG_GAIN;
            chan_gain[4 + i] = (gyro_range_reg == 2'd1) ? GYRO_GAIN_HALF : MG_GAIN;
        end
        samp_in[3]   = temp_in;
        chan_gain[3] = TEMP_GAIN;
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        ibc_div_lane u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .dividend (lane_dividend[g]),
            .divisor  (lane_divisor[g]),
            .quotient (lane_quot[g])
        );
    end

    // Scaling lanes: hold the sample, form magnitude times gain, then divide
    // by the sensitivity. Truncation toward zero works on the magnitude.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (scale_load)
                samp_reg[c] <= samp_in[c];
            if (scale_mul)
            begin
                sneg_reg[c] <= samp_reg[c][15];
                mag_reg[c]  <= scale_mag(samp_reg[c], chan_gain[c]);
            end
        end
        if (scale_div)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qmag_reg[i]     <= 21'(mag_reg[i] >> (4'd14 - {2'b00, accel_range_reg}));
                qmag_reg[4 + i] <= gyro_quot(mag_reg[4 + i], gyro_range_reg);
            end
            qmag_reg[3] <= 21'((52'(mag_reg[3]) * RECIP_17) >> RECIP_17_SHIFT);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
            sval[c] = sneg_reg[c] ? -$signed({1'b0, qmag_reg[c]})
                                  : $signed({1'b0, qmag_reg[c]});
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        accel_range_next = accel_range_reg;
        gyro_range_next  = gyro_range_reg;
        cal_samples_next = cal_samples_reg;
        cal_enable_next  = cal_enable_reg;
        abias_next       = abias_reg;
        gbias_next       = gbias_reg;
        sum_next         = sum_reg;
        taken_next       = taken_reg;
        state_next       = state_reg;
        kind_next        = kind_reg;
        pend_status_next = pend_status_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        cal_done_next    = cal_done_reg;
        amg_next         = amg_reg;
        temp_next        = temp_reg;
        gmd_next         = gmd_reg;
        ctrl             = '0;
        scale_load       = 1'b0;
        scale_mul        = 1'b0;
        scale_div        = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_ACCEL_RANGE:  accel_range_next = cfg_data[1:0];
                REG_GYRO_RANGE:   gyro_range_next  = cfg_data[1:0];
                REG_CAL_SAMPLES:  cal_samples_next = cfg_data;
                REG_CAL_ENABLE:   cal_enable_next  = cfg_data[0];
                REG_ACCEL_BIAS_X: abias_next[0]    = $signed(cfg_data);
                REG_ACCEL_BIAS_Y: abias_next[1]    = $signed(cfg_data);
                REG_ACCEL_BIAS_Z: abias_next[2]    = $signed(cfg_data);
                default:          ;
            endcase
        end

        // drop the result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next        = KIND_NONE;
                    pend_status_next = STATUS_OK;
                    step_next        = '0;
                    state_next       = ST_DONE;
                    case (command)
                        CMD_MEASURE:
                        begin
                            if (read_failed)
                                pend_status_next = STATUS_READ_ERR;
                            else
                            begin
                                kind_next  = KIND_MEAS;
                                scale_load = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        CMD_CAL:
                        begin
                            if (cal_samples_reg == 16'd0 || read_failed)
                            begin
                                pend_status_next = (cal_samples_reg == 16'd0)
                                                 ? STATUS_PARAM_ERR : STATUS_READ_ERR;
                                sum_next   = '{3{32'sd0}};
                                taken_next = '0;
                            end
                            else if (cal_finish)
                            begin
                                kind_next  = KIND_CAL;
                                ctrl.load  = 1'b1;
                                sum_next   = '{3{32'sd0}};
                                taken_next = '0;
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                sum_next   = sum_add;
                                taken_next = taken_inc;
                            end
                        end
                        CMD_CLEAR:
                            gbias_next = '{3{16'sd0}};
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                // advance the dividers on calibration, the scaling steps on measure
                ctrl.step = (kind_reg == KIND_CAL);
                scale_mul = (kind_reg == KIND_MEAS) && (step_reg == '0);
                scale_div = (kind_reg == KIND_MEAS) && (step_reg == last_step);
                step_next = STEP_W'(step_reg + 1'b1);
                if (step_reg == last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // merge lane results into the result register
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    cal_done_next  = (kind_reg == KIND_CAL);
                    for (int i = 0; i < 3; i++)
                    begin
                        amg_next[i] = (kind_reg == KIND_MEAS) ? sval[i][14:0] : '0;
                        gmd_next[i] = (kind_reg == KIND_MEAS) ? sval[4 + i] : '0;
                        if (kind_reg == KIND_CAL)
                            gbias_next[i] = lane_quot[i][15:0];
                    end
                    temp_next  = (kind_reg == KIND_MEAS) ? 15'(sval[3] + TEMP_OFFS) : '0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_range_reg <= '0;
            gyro_range_reg  <= '0;
            cal_samples_reg <= 16'd1;
            cal_enable_reg  <= 1'b1;
            abias_reg       <= '{3{16'sd0}};
            gbias_reg       <= '{3{16'sd0}};
            sum_reg         <= '{3{32'sd0}};
            taken_reg       <= '0;
            state_reg       <= ST_IDLE;
            kind_reg        <= KIND_NONE;
            pend_status_reg <= STATUS_OK;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            accel_range_reg <= accel_range_next;
            gyro_range_reg  <= gyro_range_next;
            cal_samples_reg <= cal_samples_next;
            cal_enable_reg  <= cal_enable_next;
            abias_reg       <= abias_next;
            gbias_reg       <= gbias_next;
            sum_reg         <= sum_next;
            taken_reg       <= taken_next;
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            pend_status_reg <= pend_status_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload holds without reset
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        cal_done_reg <= cal_done_next;
        amg_reg      <= amg_next;
        temp_reg     <= temp_next;
        gmd_reg      <= gmd_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign cal_done     = cal_done_reg;
    assign accel_x_mg   = amg_reg[0];
    assign accel_y_mg   = amg_reg[1];
    assign accel_z_mg   = amg_reg[2];
    assign temp_centi_c = temp_reg;
    assign gyro_x_mdps  = gmd_reg[0];
    assign gyro_y_mdps  = gmd_reg[1];
    assign gyro_z_mdps  = gmd_reg[2];

endmodule

// ----- sv/ibc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the IMU bias calibration block, bound to its top level.
// Depends on ibc_pkg.
module ibc_checker
    import ibc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic               cal_done,
    input logic signed [14:0] accel_x_mg,
    input logic signed [14:0] temp_centi_c,
    input logic signed [21:0] gyro_x_mdps
);

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a transaction is in work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |->
            !cal_done && accel_x_mg == 0 && temp_centi_c == 0 && gyro_x_mdps == 0)
        else $error("error result carries data");

    a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cal_done |-> status == STATUS_OK && accel_x_mg == 0 && gyro_x_mdps == 0)
        else $error("calibration result carries data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(gyro_x_mdps))
        else $error("stalled result changed");

endmodule

bind imu_bias_calibrate_and_scale ibc_checker u_ibc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .cal_done     (cal_done),
    .accel_x_mg   (accel_x_mg),
    .temp_centi_c (temp_centi_c),
    .gyro_x_mdps  (gyro_x_mdps)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for imu_bias_calibrate_and_scale: a directed table, then random
// phases under several register settings. It depends on ibc_pkg and the RTL.
module tb;
    import ibc_pkg::*;

    // Command code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 40;   // one divide plus margin

    typedef struct {
        logic [1:0]         command;
        logic signed [15:0] ax, ay, az, temp, gx, gy, gz;
        logic               failed;
    } sample_t;

    typedef struct {
        logic [1:0]  status;
        logic        done;
        logic [14:0] ax, ay, az, temp;
        logic [21:0] gx, gy, gz;
    } reading_t;

    typedef struct {
        sample_t  smp;
        logic     typed;     // 1: use the reading below as typed in
        reading_t rd;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = CMD_MEASURE;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, temp_raw = '0;
    logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic               read_failed = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic               cal_done;
    logic signed [14:0] accel_x_mg, accel_y_mg, accel_z_mg, temp_centi_c;
    logic signed [21:0] gyro_x_mdps, gyro_y_mdps, gyro_z_mdps;

    imu_bias_calibrate_and_scale dut (.*);

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the registers and of the calibration state.
    logic [1:0]         sh_arange, sh_grange;
    logic [15:0]        sh_count;
    logic               sh_enable;
    logic signed [15:0] sh_abias [3];
    logic signed [15:0] sh_gbias [3];
    longint             sh_sum [3];
    logic [15:0]        sh_taken;

    reading_t pending_readings [$];
    int  fail_count = 0;
    int  items_sent = 0;
    int  readings_checked = 0;
    int  cal_completions = 0;
    int  cycles = 0;
    bit  calm = 0;        // no gaps or stalls while set
    int  stall_left = 0;

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    endfunction

    function automatic logic signed [15:0] wrap16(logic signed [15:0] a, logic signed [15:0] b);
        return a - b;
    endfunction

    // Compute the reading for one sample and advance the shadow state.
    function automatic reading_t scale_and_calibrate(sample_t s);
        reading_t r;
        longint al, gl, n;
        logic signed [15:0] v [3];
        logic signed [15:0] g [3];
        r = '{default: '0};
        v[0] = s.ax; v[1] = s.ay; v[2] = s.az;
        g[0] = s.gx; g[1] = s.gy; g[2] = s.gz;
        case (s.command)
            CMD_CAL:
            begin
                if (sh_count == 0)
                begin
                    sh_sum = '{0, 0, 0};
                    sh_taken = '0;
                    r.status = STATUS_PARAM_ERR;
                end
                else if (s.failed)
                begin
                    sh_sum = '{0, 0, 0};
                    sh_taken = '0;
                    r.status = STATUS_READ_ERR;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        sh_sum[i] += longint'(g[i]);
                    sh_taken = sh_taken + 16'd1;
                    if (sh_taken >= sh_count || sh_taken == 0)
                    begin
                        n = (sh_taken == 0) ? 65536 : longint'(sh_taken);
                        for (int i = 0; i < 3; i++)
                            sh_gbias[i] = 16'(sh_sum[i] / n);
                        sh_sum = '{0, 0, 0};
                        sh_taken = '0;
                        r.done = 1'b1;
                    end
                end
            end
            CMD_CLEAR:
                sh_gbias = '{16'sd0, 16'sd0, 16'sd0};
            CMD_MEASURE:
            begin
                if (s.failed)
                    r.status = STATUS_READ_ERR;
                else
                begin
                    al = 16384 >> sh_arange;
                    case (sh_grange)
                        2'd0:    gl = 131;
                        2'd1:    gl = 66;
                        2'd2:    gl = 33;
                        default: gl = 16;
                    endcase
                    if (sh_enable)
                        for (int i = 0; i < 3; i++)
                        begin
                            v[i] = wrap16(v[i], sh_abias[i]);
                            g[i] = wrap16(g[i], sh_gbias[i]);
                        end
                    r.ax = 15'(longint'(v[0]) * 1000 / al);
                    r.ay = 15'(longint'(v[1]) * 1000 / al);
                    r.az = 15'(longint'(v[2]) * 1000 / al);
                    r.temp = 15'(longint'(s.temp) * 100 / 340 + 3653);
                    r.gx = 22'(longint'(g[0]) * 1000 / gl);
                    r.gy = 22'(longint'(g[1]) * 1000 / gl);
                    r.gz = 22'(longint'(g[2]) * 1000 / gl);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one transaction, hold it until accepted, then record its reading.
    task automatic send_sample(sample_t s, logic typed, reading_t given);
        reading_t r;
        in_valid    <= 1'b1;
        command     <= s.command;
        accel_x     <= s.ax;
        accel_y     <= s.ay;
        accel_z     <= s.az;
        temp_raw    <= s.temp;
        gyro_x      <= s.gx;
        gyro_y      <= s.gy;
        gyro_z      <= s.gz;
        read_failed <= s.failed;
        do @(posedge clk); while (in_stall);
        r = scale_and_calibrate(s);
        pending_readings.push_back(typed ? given : r);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every reading is back and the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_ACCEL_RANGE:  sh_arange = data[1:0];
            REG_GYRO_RANGE:   sh_grange = data[1:0];
            REG_CAL_SAMPLES:  sh_count = data;
            REG_CAL_ENABLE:   sh_enable = data[0];
            REG_ACCEL_BIAS_X: sh_abias[0] = data;
            REG_ACCEL_BIAS_Y: sh_abias[1] = data;
            REG_ACCEL_BIAS_Z: sh_abias[2] = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        int pick;
        pick = $urandom_range(0, 99);
        s.command = (pick < 55) ? CMD_MEASURE : (pick < 88) ? CMD_CAL :
                    (pick < 95) ? CMD_CLEAR : CMD_UNUSED;
        s.ax = rand_word(); s.ay = rand_word(); s.az = rand_word();
        s.temp = rand_word();
        s.gx = rand_word(); s.gy = rand_word(); s.gz = rand_word();
        s.failed = ($urandom_range(0, 19) == 0);
        return s;
    endfunction

    // Compare each returned transaction against the oldest pending reading,
    // and drive the output stall.
    always @(posedge clk)
    begin
        reading_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("reading returned with none pending");
                fail_count++;
            end
            else
            begin
                e = pending_readings.pop_front();
                readings_checked++;
                if (cal_done) cal_completions++;
                if (status !== e.status)
                begin $error("status exp %0d got %0d", e.status, status); fail_count++; end
                if (cal_done !== e.done)
                begin $error("cal_done exp %0d got %0d", e.done, cal_done); fail_count++; end
                if (accel_x_mg !== e.ax)
                begin $error("accel_x_mg exp %0d got %0d", $signed(e.ax), accel_x_mg); fail_count++; end
                if (accel_y_mg !== e.ay)
                begin $error("accel_y_mg exp %0d got %0d", $signed(e.ay), accel_y_mg); fail_count++; end
                if (accel_z_mg !== e.az)
                begin $error("accel_z_mg exp %0d got %0d", $signed(e.az), accel_z_mg); fail_count++; end
                if (temp_centi_c !== e.temp)
                begin $error("temp_centi_c exp %0d got %0d", $signed(e.temp), temp_centi_c); fail_count++; end
                if (gyro_x_mdps !== e.gx)
                begin $error("gyro_x_mdps exp %0d got %0d", $signed(e.gx), gyro_x_mdps); fail_count++; end
                if (gyro_y_mdps !== e.gy)
                begin $error("gyro_y_mdps exp %0d got %0d", $signed(e.gy), gyro_y_mdps); fail_count++; end
                if (gyro_z_mdps !== e.gz)
                begin $error("gyro_z_mdps exp %0d got %0d", $signed(e.gz), gyro_z_mdps); fail_count++; end
            end
        end
        // Hold stall for a random stretch now and then.
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = gap_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        row_t table_rows [$];
        sample_t zero_s, s;
        reading_t zero_r, r;
        int phases;

        // Reset values of the block.
        sh_arange = '0; sh_grange = '0; sh_count = 16'd1; sh_enable = 1'b1;
        sh_abias = '{16'sd0, 16'sd0, 16'sd0};
        sh_gbias = '{16'sd0, 16'sd0, 16'sd0};
        sh_sum = '{0, 0, 0};
        sh_taken = '0;

        zero_s = '{CMD_MEASURE, 0, 0, 0, 0, 0, 0, 0, 1'b0};
        zero_r = '{default: '0};

        // Directed table; typed readings where the answer is obvious.
        r = zero_r; r.temp = 15'd3653;
        table_rows.push_back('{zero_s, 1'b1, r});
        s = zero_s; s.failed = 1'b1; r = zero_r; r.status = STATUS_READ_ERR;
        table_rows.push_back('{s, 1'b1, r});
        s = '{CMD_MEASURE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0};
        table_rows.push_back('{s, 1'b0, zero_r});
        s = '{CMD_MEASURE, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
              -16'sh8000, -16'sh8000, -16'sh8000, 1'b0};
        table_rows.push_back('{s, 1'b0, zero_r});
        // Single-sample calibration completes at once with default count.
        s = '{CMD_CAL, 16'sh1234, 0, 0, 0, 16'sd100, -16'sd200, 16'sh7FFF, 1'b0};
        r = zero_r; r.done = 1'b1;
        table_rows.push_back('{s, 1'b1, r});
        s = '{CMD_MEASURE, 16'sd500, -16'sd500, 16'sd16384, -16'sd340,
              16'sd100, -16'sd200, -16'sh8000, 1'b0};
        table_rows.push_back('{s, 1'b0, zero_r});
        s = '{CMD_CAL, 0, 0, 0, 0, 16'sd5, 16'sd5, 16'sd5, 1'b1};
        r = zero_r; r.status = STATUS_READ_ERR;
        table_rows.push_back('{s, 1'b1, r});
        s = '{CMD_MEASURE, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00,
              16'sh0F0F, 16'shF0F0, 16'sh3C3C, 1'b0};
        table_rows.push_back('{s, 1'b0, zero_r});
        s = zero_s; s.command = CMD_CLEAR;
        table_rows.push_back('{s, 1'b1, zero_r});
        s = zero_s; s.command = CMD_UNUSED; s.ax = 16'sh7FFF;
        table_rows.push_back('{s, 1'b1, zero_r});
        s = '{CMD_MEASURE, 16'sd1, -16'sd1, 16'sd17, 16'sd3, 16'sd131, -16'sd131, 16'sd1, 1'b0};
        table_rows.push_back('{s, 1'b0, zero_r});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1;
        foreach (table_rows[i])
            send_sample(table_rows[i].smp, table_rows[i].typed, table_rows[i].rd);
        drain();

        // Random phases, each under its own register setting. The first phase
        // leaves a long calibration half done; the second lowers the count so
        // it completes early. The third runs with a zero count.
        phases = 12;
        for (int p = 0; p < phases; p++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case (p)
                0:
                begin
                    write_reg(REG_ACCEL_RANGE, 16'd3);
                    write_reg(REG_GYRO_RANGE, 16'd3);
                    write_reg(REG_CAL_SAMPLES, 16'hFFFF);
                    write_reg(REG_CAL_ENABLE, 16'd1);
                    write_reg(REG_ACCEL_BIAS_X, 16'h7FFF);
                    write_reg(REG_ACCEL_BIAS_Y, 16'h8000);
                    write_reg(REG_ACCEL_BIAS_Z, 16'h7FFF);
                end
                1:
                begin
                    write_reg(REG_ACCEL_RANGE, 16'd0);
                    write_reg(REG_GYRO_RANGE, 16'd0);
                    write_reg(REG_CAL_SAMPLES, 16'd2);
                    write_reg(REG_ACCEL_BIAS_X, 16'h8000);
                    write_reg(REG_ACCEL_BIAS_Y, 16'h7FFF);
                    write_reg(REG_ACCEL_BIAS_Z, 16'h8000);
                end
                2:
                begin
                    write_reg(REG_CAL_SAMPLES, 16'd0);
                    write_reg(REG_CAL_ENABLE, 16'd0);
                end
                default:
                begin
                    write_reg(REG_ACCEL_RANGE, 16'($urandom_range(0, 3)));
                    write_reg(REG_GYRO_RANGE, 16'($urandom_range(0, 3)));
                    write_reg(REG_CAL_SAMPLES, 16'($urandom_range(1, 6)));
                    write_reg(REG_CAL_ENABLE, 16'($urandom_range(0, 3) != 0));
                    write_reg(REG_ACCEL_BIAS_X, rand_word());
                    write_reg(REG_ACCEL_BIAS_Y, rand_word());
                    write_reg(REG_ACCEL_BIAS_Z, rand_word());
                end
            endcase
            cfg_write <= 1'b0;
            @(posedge clk);
            for (int k = 0; k < 70; k++)
                send_sample(rand_sample(), 1'b0, zero_r);
            drain();
        end

        $display("Checked %0d readings from %0d samples over %0d register settings,",
                 readings_checked, items_sent, phases + 1);
        $display("including %0d completed calibrations.", cal_completions);
        if (fail_count == 0 && pending_readings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ibc_pkg.sv
sv/ibc_div_lane.sv
sv/imu_bias_calibrate_and_scale.sv
sv/ibc_checker.sv
sim/tb.sv
